FILE: rtl/core/rtc_counter_prescaler_match_top_assert.svh
// assertion macros for the real-time counter checker
// expects clk and rst_n in the scope where a macro is used
`ifndef RTC_COUNTER_PRESCALER_MATCH_TOP_ASSERT_SVH
`define RTC_COUNTER_PRESCALER_MATCH_TOP_ASSERT_SVH

// same-cycle implication, off during reset
`define RTC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, off during reset
`define RTC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/core/rtc_pkg.sv
// shared types and codes of the real-time counter
// no dependencies
package rtc_pkg;

  localparam int DATA_W = 32;
  localparam int CTL_W  = 5;

  // function codes of a beat
  localparam logic [1:0] FUNC_TICK  = 2'd0;
  localparam logic [1:0] FUNC_READ  = 2'd1;
  localparam logic [1:0] FUNC_WRITE = 2'd2;

  // word register indexes
  localparam logic [3:0] REG_COUNT    = 4'd0;
  localparam logic [3:0] REG_MATCH    = 4'd1;
  localparam logic [3:0] REG_LOAD     = 4'd2;
  localparam logic [3:0] REG_CONTROL  = 4'd3;
  localparam logic [3:0] REG_STATUS   = 4'd4;
  localparam logic [3:0] REG_RAW      = 4'd5;
  localparam logic [3:0] REG_EOI      = 4'd6;
  localparam logic [3:0] REG_VERSION  = 4'd7;
  localparam logic [3:0] REG_PRESCALE = 4'd8;

  // control bit positions
  localparam int CTL_IE      = 0;
  localparam int CTL_MASK    = 1;
  localparam int CTL_EN      = 2;
  localparam int CTL_WEN     = 3;
  localparam int CTL_PSCLREN = 4;

  typedef struct packed {
    logic [1:0]        func;
    logic [3:0]        reg_index;
    logic [DATA_W-1:0] write_data;
  } rtc_in_t;

  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic              interrupt_line;
  } rtc_out_t;

endpackage

FILE: rtl/core/rtc_core.sv
// register file, prescaler and counter of the real-time counter
// one beat is applied per fire strobe; depends on rtc_pkg
module rtc_core
  import rtc_pkg::*;
#(
  parameter int          PRESCALE_BITS = 16,
  parameter int          COUNTER_BITS  = 32,
  parameter logic [31:0] VERSION_WORD  = 32'h0
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     fire,
  input  rtc_in_t  item,
  output rtc_out_t res
);

  localparam int PW = PRESCALE_BITS + 1;

  logic [COUNTER_BITS-1:0]  cnt_r, cnt_nxt;
  logic [COUNTER_BITS-1:0]  match_r, match_nxt;
  logic [COUNTER_BITS-1:0]  load_r, load_nxt;
  logic                     load_pend_r, load_pend_nxt;
  logic [CTL_W-1:0]         ctl_r, ctl_nxt;
  logic                     raw_r, raw_nxt;
  logic [PRESCALE_BITS-1:0] psc_val_r, psc_val_nxt;
  logic [PRESCALE_BITS-1:0] psc_cnt_r, psc_cnt_nxt;

  logic [PW-1:0]     psc_inc;
  logic [PW-1:0]     psc_eff;
  logic              cnt_clk;
  logic              irq_cur;
  logic [DATA_W-1:0] rd;

  // prescaler compare, zero divisor counts as one
  assign psc_inc = {1'b0, psc_cnt_r} + PW'(1);
  assign psc_eff = (psc_val_r == '0) ? PW'(1) : {1'b0, psc_val_r};
  assign irq_cur = raw_r & ctl_r[CTL_IE] & ~ctl_r[CTL_MASK];

  // next state for one beat
  always_comb begin
    cnt_nxt       = cnt_r;
    match_nxt     = match_r;
    load_nxt      = load_r;
    load_pend_nxt = load_pend_r;
    ctl_nxt       = ctl_r;
    raw_nxt       = raw_r;
    psc_val_nxt   = psc_val_r;
    psc_cnt_nxt   = psc_cnt_r;
    cnt_clk       = 1'b0;
    rd            = '0;
    unique case (item.func)
      FUNC_TICK: begin
        if (ctl_r[CTL_EN]) begin
          if (ctl_r[CTL_PSCLREN]) begin
            if (psc_inc >= psc_eff) begin
              psc_cnt_nxt = '0;
              cnt_clk     = 1'b1;
            end else begin
              psc_cnt_nxt = psc_inc[PRESCALE_BITS-1:0];
            end
          end else begin
            psc_cnt_nxt = '0;
            cnt_clk     = 1'b1;
          end
        end
      end
      FUNC_READ: begin
        unique case (item.reg_index)
          REG_COUNT:    rd = DATA_W'(cnt_r);
          REG_MATCH:    rd = DATA_W'(match_r);
          REG_LOAD:     rd = DATA_W'(load_r);
          REG_CONTROL:  rd = DATA_W'(ctl_r);
          REG_STATUS:   rd = DATA_W'(irq_cur);
          REG_RAW:      rd = DATA_W'(raw_r);
          REG_EOI:      raw_nxt = 1'b0;
          REG_VERSION:  rd = VERSION_WORD;
          REG_PRESCALE: rd = DATA_W'(psc_val_r);
          default:      rd = '0;
        endcase
      end
      FUNC_WRITE: begin
        unique case (item.reg_index)
          REG_MATCH:    match_nxt = item.write_data[COUNTER_BITS-1:0];
          REG_LOAD: begin
            load_nxt      = item.write_data[COUNTER_BITS-1:0];
            load_pend_nxt = 1'b1;
          end
          REG_CONTROL:  ctl_nxt = item.write_data[CTL_W-1:0];
          REG_PRESCALE: psc_val_nxt = item.write_data[PRESCALE_BITS-1:0];
          default:      ;
        endcase
      end
      default: ;
    endcase

    // counter clock: load, wrap or increment, then match check
    if (cnt_clk) begin
      if (load_pend_r) begin
        cnt_nxt       = load_r;
        load_pend_nxt = 1'b0;
      end else if (ctl_r[CTL_WEN] && (cnt_r == match_r)) begin
        cnt_nxt = '0;
      end else begin
        cnt_nxt = cnt_r + COUNTER_BITS'(1);
      end
      if (cnt_nxt == match_r) begin
        raw_nxt = 1'b1;
      end
    end
  end

  // result of the beat, interrupt taken from the state it leaves
  assign res.read_data      = rd;
  assign res.interrupt_line = raw_nxt & ctl_nxt[CTL_IE] & ~ctl_nxt[CTL_MASK];

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      match_r     <= '0;
      load_r      <= '0;
      load_pend_r <= 1'b0;
      ctl_r       <= '0;
      raw_r       <= 1'b0;
      psc_val_r   <= PRESCALE_BITS'(1);
      psc_cnt_r   <= '0;
    end else if (fire) begin
      cnt_r       <= cnt_nxt;
      match_r     <= match_nxt;
      load_r      <= load_nxt;
      load_pend_r <= load_pend_nxt;
      ctl_r       <= ctl_nxt;
      raw_r       <= raw_nxt;
      psc_val_r   <= psc_val_nxt;
      psc_cnt_r   <= psc_cnt_nxt;
    end
  end

endmodule

FILE: rtl/core/rtc_counter_prescaler_match_top.sv
// Real-time counter with prescaler and match interrupt, top level.
// Depends on rtc_pkg and rtc_core.
//
// Usage:
//   Input channel in_valid/in_stall/in_data carries one beat per accepted
//   item: a clock tick, a register read or a register write (func field).
//   Result channel out_valid/out_stall/out_data returns exactly one beat per
//   input beat, in order: read_data (register value on reads, zero
//   otherwise) and interrupt_line (state after the beat).
//   Path: an accepted beat is held in the input register, and its result is
//   written to the result register when that register is free or drained.
//   Throughput: one beat per cycle unless the receiver stalls, set by the
//   single input register feeding the register-file logic and result register.
//   When the receiver stalls, the result register holds its beat and the
//   input register can still take one more beat; after that in_stall rises
//   until the receiver takes the held result.
//   Reset (rst_n low, synchronous) empties both registers, clears count,
//   match, load, control and the raw flag, sets prescale to one.
module rtc_counter_prescaler_match_top
  import rtc_pkg::*;
#(
  parameter int          PRESCALE_BITS = 16,
  parameter int          COUNTER_BITS  = 32,
  parameter logic [31:0] VERSION_WORD  = 32'h0
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  rtc_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output rtc_out_t out_data
);

  logic     s1_vld_r, s1_vld_nxt;
  rtc_in_t  s1_item_r;
  logic     out_vld_r, out_vld_nxt;
  rtc_out_t out_data_r;
  rtc_out_t res;
  logic     adv;
  logic     in_take;

  // input register moves on when the result register is free or drained
  assign adv      = s1_vld_r & (~out_vld_r | ~out_stall);
  assign in_stall = s1_vld_r & ~adv;
  assign in_take  = in_valid & ~in_stall;

  assign s1_vld_nxt  = in_take | (s1_vld_r & ~adv);
  assign out_vld_nxt = adv | (out_vld_r & out_stall);

  rtc_core #(
    .PRESCALE_BITS (PRESCALE_BITS),
    .COUNTER_BITS  (COUNTER_BITS),
    .VERSION_WORD  (VERSION_WORD)
  ) u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (adv),
    .item  (s1_item_r),
    .res   (res)
  );

  // valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      s1_vld_r  <= s1_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_item_r <= in_data;
    end
    if (adv) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_data_r;

endmodule

FILE: rtl/core/rtc_chk.sv
// port-level checker for the real-time counter top level
// depends on rtc_pkg and rtc_counter_prescaler_match_top_assert.svh
`include "rtc_counter_prescaler_match_top_assert.svh"

module rtc_chk
  import rtc_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  input logic     in_valid,
  input logic     in_stall,
  input rtc_in_t  in_data,
  input logic     out_valid,
  input logic     out_stall,
  input rtc_out_t out_data
);

  // held result stays put
  `RTC_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "result beat changed while stalled")

  // input only backs up behind a stalled result
  `RTC_ASSERT_NOW(a_stall_cause, in_stall, out_valid && out_stall, "input stalled with result side free")

  // a new result comes from a beat accepted at the input, via the input and result registers
  `RTC_ASSERT_NOW(a_out_source, $rose(out_valid), $past(in_valid && !in_stall, 2), "result beat without accepted input")

  // nothing comes out right after reset
  `RTC_ASSERT_NOW(a_reset_empty, $past(!rst_n), !out_valid, "result valid right after reset")

endmodule

bind rtc_counter_prescaler_match_top rtc_chk u_rtc_chk (.*);
